/* design/uwas_pkg.sv */
`default_nettype none
package uwas_pkg;

    localparam int SensorCount = 4;
    localparam int UsPerCm = 58;
    localparam int NearWallCm = 10;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;
    localparam int QueueDepth = 2;

    localparam logic [CfgIdxW-1:0] REG_RANGE_LIMIT = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SIDE_BIAS = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_END_BIAS = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SIDE_BAND = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_END_BAND = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_PING_INTERVAL = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_EVAL_INTERVAL = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_DRIVE_INTERVAL = 3'd7;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_CW = 3'd1;
    localparam logic [2:0] CMD_CCW = 3'd2;
    localparam logic [2:0] CMD_LEFT = 3'd3;
    localparam logic [2:0] CMD_RIGHT = 3'd4;
    localparam logic [2:0] CMD_FORWARD = 3'd5;
    localparam logic [2:0] CMD_BACKWARD = 3'd6;
    localparam logic [2:0] CMD_STOP = 3'd7;

    localparam logic [1:0] PH_PARALLEL = 2'd0;
    localparam logic [1:0] PH_X = 2'd1;
    localparam logic [1:0] PH_Y = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    typedef struct packed {
        logic       op_poll;
        logic [15:0] echo_us;
        logic [31:0] now_ms;
        logic       facing_front;
        logic [10:0] x_target;
        logic [10:0] y_target;
    } item_t;

    typedef struct packed {
        logic       trigger_fire;
        logic [1:0] trigger_sensor;
        logic [2:0] motor_command;
        logic       checkpoint_done;
        logic [1:0] phase_now;
    } result_t;

    typedef struct packed {
        logic [9:0]  range_limit;
        logic [7:0]  side_bias;
        logic [7:0]  end_bias;
        logic [7:0]  side_band;
        logic [7:0]  end_band;
        logic [15:0] ping_interval;
        logic [15:0] eval_interval;
        logic [15:0] drive_interval;
    } cfg_t;

    function automatic logic elapsed(input logic [31:0] now, input logic [31:0] last,
                                     input logic [15:0] period);
        logic [31:0] diff;
        diff = now - last;
        return diff >= {16'd0, period};
    endfunction

endpackage
`default_nettype wire

/* design/uwas_cfg.sv */
`default_nettype none
module uwas_cfg
    import uwas_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_limit <= 10'd400;
            cfg_reg.side_bias <= 8'd0;
            cfg_reg.end_bias <= 8'd0;
            cfg_reg.side_band <= 8'd2;
            cfg_reg.end_band <= 8'd2;
            cfg_reg.ping_interval <= 16'd50;
            cfg_reg.eval_interval <= 16'd100;
            cfg_reg.drive_interval <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANGE_LIMIT: cfg_reg.range_limit <= cfg_data[9:0];
                REG_SIDE_BIAS: cfg_reg.side_bias <= cfg_data[7:0];
                REG_END_BIAS: cfg_reg.end_bias <= cfg_data[7:0];
                REG_SIDE_BAND: cfg_reg.side_band <= cfg_data[7:0];
                REG_END_BAND: cfg_reg.end_band <= cfg_data[7:0];
                REG_PING_INTERVAL: cfg_reg.ping_interval <= cfg_data;
                REG_EVAL_INTERVAL: cfg_reg.eval_interval <= cfg_data;
                REG_DRIVE_INTERVAL: cfg_reg.drive_interval <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* design/uwas_queue.sv */
`default_nettype none
module uwas_queue
    import uwas_pkg::*;
#(
    parameter int Width = 8,
    parameter int Depth = QueueDepth
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [Width-1:0] wdata,
    output logic                  full,
    input  wire logic             rd,
    output logic [Width-1:0]      rdata,
    output logic                  empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    logic [Width-1:0] mem_reg [Depth];
    logic [PtrW-1:0] wptr_reg, rptr_reg;
    logic [PtrW:0] count_reg;
    logic do_wr, do_rd;

    assign full = count_reg == (PtrW+1)'(Depth);
    assign empty = count_reg == '0;
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == PtrW'(Depth - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == PtrW'(Depth - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !empty)
        else $error("queue full and empty together");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a write");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PtrW+1)'(Depth))
        else $error("queue overfilled");

endmodule
`default_nettype wire

/* design/uwas_exec.sv */
`default_nettype none
module uwas_exec
    import uwas_pkg::*;
#(
    parameter int SENSOR_COUNT = SensorCount
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  item_t     item,
    input  wire logic item_valid,
    output logic      item_take,
    output result_t   result,
    output logic      result_valid,
    input  wire logic result_full
);

    logic [3:0]  slot_reg, slot_next;
    logic [1:0]  sensor_reg, sensor_next;
    logic        await_reg, await_next;
    logic [15:0] echo_reg, echo_next;
    logic [9:0]  dist_reg [SENSOR_COUNT];
    logic [9:0]  dist_next [SENSOR_COUNT];
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] spin_reg, spin_next, check_reg, check_next, motor_reg, motor_next;
    logic        done_reg, done_next;

    logic        fire;
    logic [2:0]  cmd;
    logic        done_pulse;
    logic [31:0] prod;
    logic [9:0]  cm;
    logic        cm_ok;
    logic [3:0]  slot_tmp;
    logic [9:0]  ysel;
    logic signed [12:0] x1, x2, y, xt, yt, xtol, ytol, d;
    logic        par, outx, outy, ylow, gate;

    assign item_take = item_valid && !result_full;

    // Division by 58 as a multiply by a scaled reciprocal; exact for 16-bit inputs.
    assign prod = echo_reg * 16'd36158;
    assign cm = prod[30:21];
    assign cm_ok = prod[31:21] <= {1'b0, cfg.range_limit};

    always_comb
    begin
        slot_next = slot_reg;
        sensor_next = sensor_reg;
        await_next = await_reg;
        echo_next = echo_reg;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            dist_next[i] = dist_reg[i];
        end
        phase_next = phase_reg;
        spin_next = spin_reg;
        check_next = check_reg;
        motor_next = motor_reg;
        done_next = done_reg;
        fire = 1'b0;
        cmd = CMD_NONE;
        done_pulse = 1'b0;
        slot_tmp = slot_reg;

        if (!item.op_poll)
        begin
            echo_next = item.echo_us;
            await_next = 1'b0;
        end
        else if (elapsed(item.now_ms, spin_reg, cfg.ping_interval))
        begin
            spin_next = item.now_ms;
            if (!await_reg)
            begin
                case (slot_reg)
                    4'd2:
                    begin
                        if (cm_ok) dist_next[0] = cm;
                    end
                    4'd4:
                    begin
                        if (cm_ok) dist_next[1] = cm;
                        if (item.facing_front) slot_tmp = 4'd6;
                    end
                    4'd6:
                    begin
                        if (cm_ok) dist_next[2] = cm;
                        slot_tmp = 4'd1;
                    end
                    4'd8:
                    begin
                        if (cm_ok) dist_next[3] = cm;
                        slot_tmp = 4'd1;
                    end
                    default: ;
                endcase
                slot_next = slot_tmp + 4'd1;
                case (slot_next)
                    4'd2: sensor_next = 2'd0;
                    4'd4: sensor_next = 2'd1;
                    4'd6: sensor_next = 2'd2;
                    4'd8: sensor_next = 2'd3;
                    default: ;
                endcase
                await_next = 1'b1;
                fire = 1'b1;
            end
        end

        // The evaluation sees any reading stored by this same poll.
        ysel = item.facing_front ? dist_next[3] : dist_next[2];
        x1 = 13'(dist_next[0]) + 13'(cfg.side_bias);
        x2 = 13'(dist_next[1]) + 13'(cfg.side_bias);
        y = 13'(ysel) + 13'(cfg.end_bias);
        xt = 13'(item.x_target);
        yt = 13'(item.y_target);
        xtol = 13'(cfg.side_band);
        ytol = 13'(cfg.end_band);
        d = x1 - x2;
        par = (d <= xtol) && (d >= -xtol);
        outx = (x1 < xt - xtol) || (x1 > xt + xtol);
        outy = (y < yt - ytol) || (y > yt + ytol);
        ylow = y < yt - ytol;
        gate = elapsed(item.now_ms, motor_reg, cfg.drive_interval);

        if (item.op_poll && elapsed(item.now_ms, check_reg, cfg.eval_interval))
        begin
            check_next = item.now_ms;
            done_next = 1'b0;
            if (dist_next[0] != '0 && dist_next[1] != '0 && ysel != '0)
            begin
                case (phase_reg)
                    PH_PARALLEL:
                    begin
                        if (gate)
                        begin
                            motor_next = item.now_ms;
                            if (!par) cmd = (x1 > x2) ? CMD_CW : CMD_CCW;
                            else phase_next = PH_X;
                        end
                    end
                    PH_X:
                    begin
                        if (gate)
                        begin
                            motor_next = item.now_ms;
                            if (outx)
                            begin
                                if (x1 < 13'(NearWallCm)) cmd = CMD_RIGHT;
                                else cmd = (x1 < xt - xtol) ? CMD_LEFT : CMD_RIGHT;
                            end
                            else
                            begin
                                phase_next = par ? PH_Y : PH_PARALLEL;
                            end
                        end
                    end
                    PH_Y:
                    begin
                        if (outy)
                        begin
                            if (gate)
                            begin
                                motor_next = item.now_ms;
                                if (item.facing_front) cmd = ylow ? CMD_BACKWARD : CMD_FORWARD;
                                else cmd = ylow ? CMD_FORWARD : CMD_BACKWARD;
                            end
                        end
                        else if (!outx && par)
                        begin
                            motor_next = item.now_ms;
                            cmd = CMD_STOP;
                            phase_next = PH_DONE;
                            done_next = 1'b1;
                            done_pulse = 1'b1;
                        end
                        else if (gate)
                        begin
                            motor_next = item.now_ms;
                            phase_next = PH_PARALLEL;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            sensor_reg <= '0;
            await_reg <= 1'b0;
            echo_reg <= '0;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                dist_reg[i] <= '0;
            end
            phase_reg <= PH_PARALLEL;
            spin_reg <= '0;
            check_reg <= '0;
            motor_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (item_take)
        begin
            slot_reg <= slot_next;
            sensor_reg <= sensor_next;
            await_reg <= await_next;
            echo_reg <= echo_next;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                dist_reg[i] <= dist_next[i];
            end
            phase_reg <= phase_next;
            spin_reg <= spin_next;
            check_reg <= check_next;
            motor_reg <= motor_next;
            done_reg <= done_next;
        end
    end

    assign result_valid = item_take;
    assign result.trigger_fire = fire;
    assign result.trigger_sensor = sensor_next;
    assign result.motor_command = cmd;
    assign result.checkpoint_done = done_pulse;
    assign result.phase_now = phase_next;

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && done_pulse) |=> phase_reg == PH_DONE && done_reg)
        else $error("done pulse without done phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("left done phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && fire) |=> await_reg)
        else $error("trigger without awaiting echo");

endmodule
`default_nettype wire

/* design/ultrasonic_wall_alignment_sequencer.sv */
// Wall-alignment sequencer for four ultrasonic sensors. Push echo events and poll
// events; each accepted item yields exactly one result with trigger, motor command,
// done pulse and phase. An input queue decouples the front from the execution unit,
// which retires one item per cycle, and a result queue holds results until popped,
// so the sustained rate is one item per clock while the result side keeps up. An item
// is stored in the input queue and then in the result queue before it reaches the result ports.
`default_nettype none
module ultrasonic_wall_alignment_sequencer
    import uwas_pkg::*;
#(
    parameter int SENSOR_COUNT = SensorCount
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                operation,
    input  wire logic [15:0]         echo_us,
    input  wire logic [31:0]         now_ms,
    input  wire logic                facing_front,
    input  wire logic [10:0]         x_target,
    input  wire logic [10:0]         y_target,
    output logic                     empty,
    input  wire logic                pop,
    output logic                     trigger_fire,
    output logic [1:0]               trigger_sensor,
    output logic [2:0]               motor_command,
    output logic                     checkpoint_done,
    output logic [1:0]               phase_now
);

    cfg_t    cfg;
    item_t   in_item, q_item;
    result_t res, out_res;
    logic    q_empty, take, res_valid, res_full;

    assign in_item = '{op_poll: operation, echo_us: echo_us, now_ms: now_ms,
                       facing_front: facing_front, x_target: x_target,
                       y_target: y_target};

    uwas_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    uwas_queue #(.Width($bits(item_t)), .Depth(QueueDepth)) u_inq (
        .clk(clk), .rst_n(rst_n), .wr(push), .wdata(in_item), .full(full),
        .rd(take), .rdata(q_item), .empty(q_empty)
    );

    uwas_exec #(.SENSOR_COUNT(SENSOR_COUNT)) u_exec (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .item(q_item), .item_valid(!q_empty),
        .item_take(take), .result(res), .result_valid(res_valid),
        .result_full(res_full)
    );

    uwas_queue #(.Width($bits(result_t)), .Depth(QueueDepth)) u_outq (
        .clk(clk), .rst_n(rst_n), .wr(res_valid), .wdata(res), .full(res_full),
        .rd(pop), .rdata(out_res), .empty(empty)
    );

    assign trigger_fire = out_res.trigger_fire;
    assign trigger_sensor = out_res.trigger_sensor;
    assign motor_command = out_res.motor_command;
    assign checkpoint_done = out_res.checkpoint_done;
    assign phase_now = out_res.phase_now;

endmodule
`default_nettype wire
